// ===== hw/rtl/sgm_pkg.sv =====
package sgm_pkg;

    localparam int PIX_W          = 8;
    localparam int GRAD_W         = 11;
    localparam int MAG_W          = 11;
    localparam int WIDTH_FIELD_W  = 11;
    localparam int HEIGHT_FIELD_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 1;

    localparam int SQ_W   = 2 * GRAD_W - 2;
    localparam int SUM_W  = SQ_W + 1;
    localparam int ROOT_W = MAG_W;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [GRAD_W-1:0] grad_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [SQ_W-1:0]          sq_t;
    typedef logic [SUM_W-1:0]         sum_t;

    typedef struct packed {
        logic res_valid;
        logic frame_end;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } ctrl_t;

    typedef struct packed {
        pix_t up;
        pix_t mid;
        pix_t pix;
    } column_t;

endpackage

// ===== hw/rtl/sgm_line_store.sv =====
module sgm_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 load,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  sgm_pkg::pix_t        pix,
    input  sgm_pkg::ctrl_t       ctrl,
    output logic                 item_valid,
    output sgm_pkg::column_t     col,
    output sgm_pkg::ctrl_t       ctrl_out
);

    localparam int AW = $clog2(DEPTH);

    sgm_pkg::pix_t  upper_mem [DEPTH];
    sgm_pkg::pix_t  middle_mem [DEPTH];

    sgm_pkg::pix_t  rd_up_reg;
    sgm_pkg::pix_t  rd_mid_reg;
    sgm_pkg::pix_t  fwd_up_reg;
    sgm_pkg::pix_t  fwd_mid_reg;
    sgm_pkg::pix_t  pix_b_reg;
    sgm_pkg::ctrl_t ctrl_b_reg;
    logic [AW-1:0]  addr_b_reg;
    logic           vb_reg;
    logic           vb_next;
    logic           fwd_reg;
    logic           fwd_next;
    sgm_pkg::pix_t  up_eff;
    sgm_pkg::pix_t  mid_eff;

    always_comb
    begin
        up_eff   = fwd_reg ? fwd_up_reg : rd_up_reg;
        mid_eff  = fwd_reg ? fwd_mid_reg : rd_mid_reg;
        vb_next  = vb_reg;
        fwd_next = fwd_reg;
        if (adv)
        begin
            vb_next  = load;
            fwd_next = load && vb_reg && (addr_b_reg == addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_up_reg  <= upper_mem[addr];
            rd_mid_reg <= middle_mem[addr];
        end
        if (adv && vb_reg)
        begin
            upper_mem[addr_b_reg]  <= mid_eff;
            middle_mem[addr_b_reg] <= pix_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_b_reg  <= addr;
            pix_b_reg   <= pix;
            ctrl_b_reg  <= ctrl;
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= pix_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg  <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            vb_reg  <= vb_next;
            fwd_reg <= fwd_next;
        end
    end

    assign item_valid = vb_reg;
    assign col        = '{up: up_eff, mid: mid_eff, pix: pix_b_reg};
    assign ctrl_out   = ctrl_b_reg;

    a_fwd_only_with_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> vb_reg)
        else $error("forward flag set without an item in the write stage");

endmodule

// ===== hw/rtl/sgm_kernel.sv =====
module sgm_kernel (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               item_valid,
    input  sgm_pkg::column_t   col,
    input  sgm_pkg::ctrl_t     ctrl,
    output logic               sum_valid,
    output sgm_pkg::sum_t      sum,
    output sgm_pkg::grad_t     sum_gx,
    output sgm_pkg::grad_t     sum_gy,
    output logic               sum_frame_end
);

    sgm_pkg::pix_t  win_reg [3][3];
    sgm_pkg::ctrl_t ctrl_c_reg;
    logic           vc_reg;

    sgm_pkg::grad_t s [3][3];
    sgm_pkg::grad_t gx;
    sgm_pkg::grad_t gy;

    logic           vd_reg;
    sgm_pkg::grad_t gx_d_reg;
    sgm_pkg::grad_t gy_d_reg;
    logic           fe_d_reg;

    logic signed [2*sgm_pkg::GRAD_W-1:0] px;
    logic signed [2*sgm_pkg::GRAD_W-1:0] py;

    logic           ve_reg;
    sgm_pkg::sq_t   sqx_e_reg;
    sgm_pkg::sq_t   sqy_e_reg;
    sgm_pkg::grad_t gx_e_reg;
    sgm_pkg::grad_t gy_e_reg;
    logic           fe_e_reg;

    logic           vf_reg;
    sgm_pkg::sum_t  sum_f_reg;
    sgm_pkg::grad_t gx_f_reg;
    sgm_pkg::grad_t gy_f_reg;
    logic           fe_f_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if ((r == 0 && ctrl_c_reg.top) || (r == 2 && ctrl_c_reg.bottom) ||
                    (k == 0 && ctrl_c_reg.left) || (k == 2 && ctrl_c_reg.right))
                begin
                    s[r][k] = '0;
                end
                else
                begin
                    s[r][k] = $signed({3'b000, win_reg[r][k]});
                end
            end
        end
        gx = (s[0][2] - s[0][0]) + ((s[1][2] - s[1][0]) <<< 1) + (s[2][2] - s[2][0]);
        gy = (s[2][0] - s[0][0]) + ((s[2][1] - s[0][1]) <<< 1) + (s[2][2] - s[0][2]);
        px = gx_d_reg * gx_d_reg;
        py = gy_d_reg * gy_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (item_valid)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= col.up;
                win_reg[1][2] <= col.mid;
                win_reg[2][2] <= col.pix;
            end
            vc_reg <= item_valid && ctrl.res_valid;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctrl_c_reg <= ctrl;
            gx_d_reg   <= gx;
            gy_d_reg   <= gy;
            fe_d_reg   <= ctrl_c_reg.frame_end;
            sqx_e_reg  <= px[sgm_pkg::SQ_W-1:0];
            sqy_e_reg  <= py[sgm_pkg::SQ_W-1:0];
            gx_e_reg   <= gx_d_reg;
            gy_e_reg   <= gy_d_reg;
            fe_e_reg   <= fe_d_reg;
            sum_f_reg  <= {1'b0, sqx_e_reg} + {1'b0, sqy_e_reg};
            gx_f_reg   <= gx_e_reg;
            gy_f_reg   <= gy_e_reg;
            fe_f_reg   <= fe_e_reg;
        end
    end

    assign sum_valid     = vf_reg;
    assign sum           = sum_f_reg;
    assign sum_gx        = gx_f_reg;
    assign sum_gy        = gy_f_reg;
    assign sum_frame_end = fe_f_reg;

endmodule

// ===== hw/rtl/sgm_isqrt.sv =====
module sgm_isqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  sgm_pkg::sum_t     in_sum,
    input  sgm_pkg::grad_t    in_gx,
    input  sgm_pkg::grad_t    in_gy,
    input  logic              in_frame_end,
    output logic              res_valid,
    output sgm_pkg::mag_t     res_mag,
    output sgm_pkg::grad_t    res_gx,
    output sgm_pkg::grad_t    res_gy,
    output logic              res_frame_end
);

    localparam int N = sgm_pkg::ROOT_W;

    logic                          valid_reg [N];
    logic [sgm_pkg::RAD_W-1:0]     rad_reg [N];
    logic [sgm_pkg::REM_W-1:0]     rem_reg [N];
    logic [sgm_pkg::ROOT_W-1:0]    root_reg [N];
    sgm_pkg::grad_t                gx_reg [N];
    sgm_pkg::grad_t                gy_reg [N];
    logic                          fe_reg [N];

    logic                          v_in [N];
    logic [sgm_pkg::RAD_W-1:0]     rad_in [N];
    logic [sgm_pkg::REM_W-1:0]     rem_in [N];
    logic [sgm_pkg::ROOT_W-1:0]    root_in [N];
    sgm_pkg::grad_t                gx_in [N];
    sgm_pkg::grad_t                gy_in [N];
    logic                          fe_in [N];

    logic [sgm_pkg::REM_W-1:0]     rem_t [N];
    logic [sgm_pkg::REM_W-1:0]     trial [N];
    logic [sgm_pkg::RAD_W-1:0]     rad_next [N];
    logic [sgm_pkg::REM_W-1:0]     rem_next [N];
    logic [sgm_pkg::ROOT_W-1:0]    root_next [N];

    always_comb
    begin
        v_in[0]    = in_valid;
        rad_in[0]  = {1'b0, in_sum};
        rem_in[0]  = '0;
        root_in[0] = '0;
        gx_in[0]   = in_gx;
        gy_in[0]   = in_gy;
        fe_in[0]   = in_frame_end;
        for (int k = 1; k < N; k++)
        begin
            v_in[k]    = valid_reg[k-1];
            rad_in[k]  = rad_reg[k-1];
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
            gx_in[k]   = gx_reg[k-1];
            gy_in[k]   = gy_reg[k-1];
            fe_in[k]   = fe_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            rem_t[k]    = {rem_in[k][sgm_pkg::REM_W-3:0], rad_in[k][sgm_pkg::RAD_W-1 -: 2]};
            trial[k]    = {1'b0, root_in[k], 2'b01};
            rad_next[k] = {rad_in[k][sgm_pkg::RAD_W-3:0], 2'b00};
            if (rem_t[k] >= trial[k])
            begin
                rem_next[k]  = rem_t[k] - trial[k];
                root_next[k] = {root_in[k][sgm_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem_t[k];
                root_next[k] = {root_in[k][sgm_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= v_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                gx_reg[k]   <= gx_in[k];
                gy_reg[k]   <= gy_in[k];
                fe_reg[k]   <= fe_in[k];
            end
        end
    end

    assign res_valid     = valid_reg[N-1];
    assign res_mag       = root_reg[N-1];
    assign res_gx        = gx_reg[N-1];
    assign res_gy        = gy_reg[N-1];
    assign res_frame_end = fe_reg[N-1];

    a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |->
            (int'(res_mag) * int'(res_mag) <=
                 int'(res_gx) * int'(res_gx) + int'(res_gy) * int'(res_gy)) &&
            ((int'(res_mag) + 1) * (int'(res_mag) + 1) >
                 int'(res_gx) * int'(res_gx) + int'(res_gy) * int'(res_gy)))
        else $error("magnitude is not the floor root of the squared gradients");

endmodule

// ===== hw/rtl/sobel_gradient_magnitude_core.sv =====
// channel  | direction | handshake            | word
// ---------+-----------+----------------------+-----------------------------------------
// cfg      | in        | cfg_write            | cfg_index, cfg_data
// in       | in        | in_valid / in_stall  | pixel, flush
// out      | out       | out_valid / out_stall| grad_x, grad_y, magnitude, frame_end
//
// One word accepted per cycle while in_stall is low; a word passes through the line store
// read, window, gradient, square, sum, and an 11-stage bit-per-stage square root pipeline.
// The result for frame pixel k comes with input word k + frame_width + 1.
// Reset clears all counters and valid flags; frame_width and frame_height return to 512
// (at most MAX_WIDTH and MAX_HEIGHT). While out_valid is high and out_stall is asserted
// the whole pipeline holds and in_stall is high.
module sobel_gradient_magnitude_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [sgm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sgm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sgm_pkg::PIX_W-1:0]            pixel,
    input  logic                                 flush,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [sgm_pkg::GRAD_W-1:0]    grad_x,
    output logic signed [sgm_pkg::GRAD_W-1:0]    grad_y,
    output logic [sgm_pkg::MAG_W-1:0]            magnitude,
    output logic                                 frame_end
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int ORW = $clog2(MAX_HEIGHT);
    localparam int WIDTH_RESET  = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
    localparam int HEIGHT_RESET = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;

    logic [WW-1:0]  width_reg;
    logic [WW-1:0]  width_next;
    logic [HW-1:0]  height_reg;
    logic [HW-1:0]  height_next;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;
    logic [CW-1:0]  ocol_reg;
    logic [CW-1:0]  ocol_next;
    logic [ORW-1:0] orow_reg;
    logic [ORW-1:0] orow_next;

    logic [sgm_pkg::WIDTH_FIELD_W-1:0]  wf;
    logic [sgm_pkg::HEIGHT_FIELD_W-1:0] hf;
    logic [WW-1:0]  width_clamped;
    logic [HW-1:0]  height_clamped;

    logic [CW-1:0]  wm1;
    logic [ORW-1:0] hm1;
    logic [RW-1:0]  hp1;
    logic           adv;
    logic           accept;
    logic           produce;
    logic           last;
    sgm_pkg::pix_t  pix_in;
    sgm_pkg::ctrl_t ctrl_in;

    logic             ls_item_valid;
    sgm_pkg::column_t ls_col;
    sgm_pkg::ctrl_t   ls_ctrl;

    logic           k_valid;
    sgm_pkg::sum_t  k_sum;
    sgm_pkg::grad_t k_gx;
    sgm_pkg::grad_t k_gy;
    logic           k_fe;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;
    assign pix_in   = flush ? '0 : pixel;

    always_comb
    begin
        wf = cfg_data[sgm_pkg::WIDTH_FIELD_W-1:0];
        hf = cfg_data[sgm_pkg::HEIGHT_FIELD_W-1:0];
        if (int'(wf) < 2)
        begin
            width_clamped = WW'(2);
        end
        else if (int'(wf) > MAX_WIDTH)
        begin
            width_clamped = WW'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = WW'(wf);
        end
        if (int'(hf) < 2)
        begin
            height_clamped = HW'(2);
        end
        else if (int'(hf) > MAX_HEIGHT)
        begin
            height_clamped = HW'(MAX_HEIGHT);
        end
        else
        begin
            height_clamped = HW'(hf);
        end
    end

    always_comb
    begin
        wm1     = CW'(width_reg - WW'(1));
        hm1     = ORW'(height_reg - HW'(1));
        hp1     = RW'(height_reg) + RW'(1);
        produce = (row_reg > RW'(1)) || (row_reg == RW'(1) && col_reg != '0);
        last    = (row_reg == hp1) && (col_reg == '0);

        ctrl_in.res_valid = produce;
        ctrl_in.frame_end = (orow_reg == hm1) && (ocol_reg == wm1);
        ctrl_in.top       = (orow_reg == '0);
        ctrl_in.bottom    = (orow_reg >= hm1);
        ctrl_in.left      = (ocol_reg == '0);
        ctrl_in.right     = (ocol_reg == wm1);

        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                sgm_pkg::REG_FRAME_WIDTH:  width_next  = width_clamped;
                sgm_pkg::REG_FRAME_HEIGHT: height_next = height_clamped;
                default:                   width_next  = width_reg;
            endcase
            col_next  = '0;
            row_next  = '0;
            ocol_next = '0;
            orow_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                col_next  = '0;
                row_next  = '0;
                ocol_next = '0;
                orow_next = '0;
            end
            else
            begin
                if (col_reg == wm1)
                begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
                if (produce)
                begin
                    if (ocol_reg == wm1)
                    begin
                        ocol_next = '0;
                        orow_next = orow_reg + ORW'(1);
                    end
                    else
                    begin
                        ocol_next = ocol_reg + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(WIDTH_RESET);
            height_reg <= HW'(HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
        end
    end

    sgm_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .load       (accept),
        .addr       (col_reg),
        .pix        (pix_in),
        .ctrl       (ctrl_in),
        .item_valid (ls_item_valid),
        .col        (ls_col),
        .ctrl_out   (ls_ctrl)
    );

    sgm_kernel u_kernel (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .item_valid    (ls_item_valid),
        .col           (ls_col),
        .ctrl          (ls_ctrl),
        .sum_valid     (k_valid),
        .sum           (k_sum),
        .sum_gx        (k_gx),
        .sum_gy        (k_gy),
        .sum_frame_end (k_fe)
    );

    sgm_isqrt u_isqrt (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (k_valid),
        .in_sum        (k_sum),
        .in_gx         (k_gx),
        .in_gy         (k_gy),
        .in_frame_end  (k_fe),
        .res_valid     (out_valid),
        .res_mag       (magnitude),
        .res_gx        (grad_x),
        .res_gy        (grad_y),
        .res_frame_end (frame_end)
    );

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= hp1)
        else $error("input row ran past the drain rows");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= wm1)
        else $error("input column ran past the frame width");

    a_last_is_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |-> (produce && ctrl_in.frame_end))
        else $error("drain end reached without the frame end result");

endmodule

// ===== tb/tb_sobel_gradient_magnitude_core.sv =====
module tb_sobel_gradient_magnitude_core;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 4096;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_WORDS  = 1050;

    class sobel_scoreboard #(int MAX_COLS = 1024, int MAX_ROWS = 4096);
        typedef struct {
            sgm_pkg::grad_t gx;
            sgm_pkg::grad_t gy;
            sgm_pkg::mag_t  mag;
            logic           fe;
        } gradient_word_t;

        gradient_word_t awaited[$];
        int             width;
        int             height;
        int             errors;
        int             checked;
        int             col;
        int             row;
        int             out_count;
        sgm_pkg::pix_t  upper_row [MAX_COLS];
        sgm_pkg::pix_t  middle_row [MAX_COLS];
        sgm_pkg::pix_t  win [3][3];

        function new();
            width   = 512;
            height  = 512;
            errors  = 0;
            checked = 0;
            foreach (upper_row[i])
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[r, k])
                win[r][k] = '0;
            restart();
        endfunction

        function void restart();
            col       = 0;
            row       = 0;
            out_count = 0;
        endfunction

        function int clamp(int v, int lo, int hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int floor_root(int v);
            int root;
            int trial;
            root = 0;
            for (int b = 11; b >= 0; b--)
            begin
                trial = root | (1 << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void write_register(logic [sgm_pkg::CFG_INDEX_W-1:0] idx,
                                     logic [sgm_pkg::CFG_DATA_W-1:0] data);
            if (idx == sgm_pkg::REG_FRAME_WIDTH)
                width = clamp(int'(data[sgm_pkg::WIDTH_FIELD_W-1:0]), 2, MAX_COLS);
            else if (idx == sgm_pkg::REG_FRAME_HEIGHT)
                height = clamp(int'(data), 2, MAX_ROWS);
            restart();
        endfunction

        function void note_input(sgm_pkg::pix_t p, logic f);
            sgm_pkg::pix_t  pv;
            sgm_pkg::pix_t  up;
            sgm_pkg::pix_t  mid;
            int             c;
            int             pos;
            int             cr;
            int             cc;
            int             gx;
            int             gy;
            int             root;
            int             v [3][3];
            gradient_word_t res;
            pv  = f ? '0 : p;
            c   = col % MAX_COLS;
            pos = row * width + col;
            up  = upper_row[c];
            mid = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = pv;
            for (int r = 0; r < 3; r++)
            begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = up;
            win[1][2] = mid;
            win[2][2] = pv;
            if (pos >= width + 1)
            begin
                cr = out_count / width;
                cc = out_count % width;
                for (int r = 0; r < 3; r++)
                    for (int k = 0; k < 3; k++)
                        v[r][k] = ((r == 0 && cr == 0) || (r == 2 && cr + 1 >= height) ||
                                   (k == 0 && cc == 0) || (k == 2 && cc + 1 >= width))
                                  ? 0 : int'(win[r][k]);
                gx = (v[0][2] - v[0][0]) + 2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
                gy = (v[2][0] - v[0][0]) + 2 * (v[2][1] - v[0][1]) + (v[2][2] - v[0][2]);
                root    = floor_root(gx * gx + gy * gy);
                res.gx  = gx[sgm_pkg::GRAD_W-1:0];
                res.gy  = gy[sgm_pkg::GRAD_W-1:0];
                res.mag = root[sgm_pkg::MAG_W-1:0];
                res.fe  = (out_count + 1 == width * height);
                awaited.push_back(res);
                out_count++;
            end
            if (pos >= width * height + width)
                restart();
            else
            begin
                col++;
                if (col >= width)
                begin
                    col = 0;
                    row++;
                end
            end
        endfunction

        task report(string msg);
            if (errors < 50)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(sgm_pkg::grad_t gx, sgm_pkg::grad_t gy, sgm_pkg::mag_t mag,
                          logic fe);
            gradient_word_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected word grad_x=%0d grad_y=%0d magnitude=%0d",
                                 gx, gy, mag));
                return;
            end
            want = awaited.pop_front();
            if (gx !== want.gx)
                report($sformatf("word %0d grad_x %0d, want %0d", checked, gx, want.gx));
            if (gy !== want.gy)
                report($sformatf("word %0d grad_y %0d, want %0d", checked, gy, want.gy));
            if (mag !== want.mag)
                report($sformatf("word %0d magnitude %0d, want %0d", checked, mag, want.mag));
            if (fe !== want.fe)
                report($sformatf("word %0d frame_end %b, want %b", checked, fe, want.fe));
            checked++;
        endtask
    endclass

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    typedef enum int {
        PIX_UNIFORM,
        PIX_EXTREME,
        PIX_RAMP
    } pixel_style_e;

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  cfg_write;
    logic [sgm_pkg::CFG_INDEX_W-1:0]       cfg_index;
    logic [sgm_pkg::CFG_DATA_W-1:0]        cfg_data;
    logic                                  in_valid;
    logic                                  in_stall;
    logic [sgm_pkg::PIX_W-1:0]             pixel;
    logic                                  flush;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic signed [sgm_pkg::GRAD_W-1:0]     grad_x;
    logic signed [sgm_pkg::GRAD_W-1:0]     grad_y;
    logic [sgm_pkg::MAG_W-1:0]             magnitude;
    logic                                  frame_end;

    sobel_scoreboard #(MAX_W, MAX_H) sb;

    int          burst_left  = 0;
    int          words_sent  = 0;
    stall_mode_e stall_mode  = STALL_NONE;
    int          stall_left  = 0;
    int          stall_phase = 0;

    logic [8:0] directed_words [26] = '{
        9'h000, 9'h04D, 9'h0FF, 9'h000, 9'h0C8, 9'h0FF, 9'h000, 9'h00D, 9'h0FF,
        9'h100, 9'h0FF, 9'h100, 9'h100,
        9'h0FF, 9'h0FF, 9'h0FF, 9'h009, 9'h1AB, 9'h009, 9'h000, 9'h000, 9'h000,
        9'h100, 9'h100, 9'h100, 9'h100
    };

    sobel_gradient_magnitude_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .flush     (flush),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .grad_x    (grad_x),
        .grad_y    (grad_y),
        .magnitude (magnitude),
        .frame_end (frame_end)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(grad_x, grad_y, magnitude, frame_end);
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 200);
        end
        else
            stall_left--;
        stall_phase++;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_COIN:     out_stall <= ($urandom_range(0, 1) == 0);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            default:        out_stall <= (stall_phase % 7 < 3);
        endcase
    end

    task automatic push_word(input sgm_pkg::pix_t p, input logic f);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        flush    <= f;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(p, f);
        burst_left--;
        words_sent++;
    endtask

    task automatic drain_to_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_size(input logic [sgm_pkg::CFG_DATA_W-1:0] width_raw,
                                    input logic [sgm_pkg::CFG_DATA_W-1:0] height_raw);
        cfg_write <= 1'b1;
        cfg_index <= sgm_pkg::REG_FRAME_WIDTH;
        cfg_data  <= width_raw;
        @(posedge clk);
        sb.write_register(sgm_pkg::REG_FRAME_WIDTH, width_raw);
        cfg_index <= sgm_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= height_raw;
        @(posedge clk);
        sb.write_register(sgm_pkg::REG_FRAME_HEIGHT, height_raw);
        cfg_write <= 1'b0;
    endtask

    task automatic send_frame(input int w, input int h, input int stop_at,
                              input pixel_style_e style);
        int            count;
        sgm_pkg::pix_t p;
        logic          f;
        count = (stop_at > 0) ? stop_at : w * h + w + 1;
        for (int k = 0; k < count; k++)
        begin
            if (k < w * h)
            begin
                case (style)
                    PIX_UNIFORM: p = sgm_pkg::pix_t'($urandom_range(0, 255));
                    PIX_EXTREME: p = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                    default:     p = sgm_pkg::pix_t'(((k % w) * 255 / (w - 1) +
                                                      (k / w) * 37) % 256);
                endcase
                f = ($urandom_range(0, 31) == 0);
            end
            else
            begin
                p = sgm_pkg::pix_t'($urandom_range(0, 255));
                f = ($urandom_range(0, 5) != 0);
            end
            push_word(p, f);
        end
    endtask

    initial
    begin
        int                               wsel;
        int                               hsel;
        int                               nframes;
        int                               total;
        int                               stop;
        int                               target;
        logic [sgm_pkg::CFG_DATA_W-1:0]   wr;
        logic [sgm_pkg::CFG_DATA_W-1:0]   hr;
        pixel_style_e                     style;
        sb        = new();
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel     = '0;
        flush     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // run a few results on the reset frame size
        for (int k = 0; k < sb.width + 5; k++)
            push_word(sgm_pkg::pix_t'($urandom_range(0, 255)), 1'b0);
        drain_to_idle();

        write_frame_size(13'd3, 13'd3);
        foreach (directed_words[i])
            push_word(directed_words[i][7:0], directed_words[i][8]);
        drain_to_idle();

        write_frame_size(13'd0, 13'h1FFF);
        for (int k = 0; k < 60; k++)
            push_word(sgm_pkg::pix_t'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        drain_to_idle();

        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            case ($urandom_range(0, 15))
                0:       wsel = $urandom_range(0, 1);
                1:       wsel = $urandom_range(13, 40);
                default: wsel = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 15))
                0:       hsel = $urandom_range(0, 1);
                1:       hsel = $urandom_range(11, 24);
                default: hsel = $urandom_range(2, 10);
            endcase
            wr = {2'($urandom_range(0, 3)), 11'(wsel)};
            hr = 13'(hsel);
            write_frame_size(wr, hr);
            nframes = $urandom_range(1, 3);
            style   = pixel_style_e'($urandom_range(0, 2));
            for (int n = 0; n < nframes; n++)
            begin
                total = sb.width * sb.height + sb.width + 1;
                stop  = (n == nframes - 1 && $urandom_range(0, 7) == 0)
                        ? $urandom_range(1, total - 1) : 0;
                send_frame(sb.width, sb.height, stop, style);
            end
            drain_to_idle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
